// File: src/pprle_pkg.sv
// Shared types and constants for the planar plane RLE decoder.
package pprle_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned CNT_W      = 25;
  localparam int unsigned RAW_W      = 4;
  localparam int unsigned RUN_W      = 6;
  localparam int unsigned POS_W      = 12;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PLANE_WIDTH   = 2'd0;
  localparam cfg_idx_t CFG_PLANE_HEIGHT  = 2'd1;
  localparam cfg_idx_t CFG_VERTICAL_FLIP = 2'd2;

  typedef enum logic [1:0] {
    STATUS_PIXEL     = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_EARLY_END = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ERR_OVF,
    S_ERR_EARLY,
    S_RAW_RD,
    S_RAW_PIX,
    S_RUN_RD,
    S_RUN_PIX
  } state_e;

  typedef struct packed {
    logic    capture;
    logic    count;
    logic    restart;
    logic    latch_err;
    logic    set_pending;
    logic    load_run;
    logic    mem_rd;
    logic    raw_pix;
    logic    run_pix;
    logic    err_emit;
    status_e err_status;
  } cmd_t;

  typedef struct packed {
    logic err_latched;
    logic last;
    logic ctl_mode;
    logic overflow;
    logic ctl_fin_ok;
    logic raw_fin_ok;
    logic ctl_raw_nz;
    logic ctl_run_nz;
    logic raw_left_one;
    logic run_left_zero;
    logic run_left_one;
    logic pix_done;
    logic out_free;
  } stat_t;

endpackage

// File: src/pprle_in_if.sv
// Input channel: one compressed source byte per transfer.
interface pprle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: src/pprle_out_if.sv
// Output channel: one decoded pixel or error report per transfer.
interface pprle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_value;
  logic [11:0] column;
  logic [11:0] row;
  logic [1:0]  status;
  logic        run_last;
  logic        plane_done;
  logic [24:0] bytes_used;

  modport source (output valid, output pixel_value, output column, output row,
                  output status, output run_last, output plane_done,
                  output bytes_used, input ready);
  modport sink (input valid, input pixel_value, input column, input row,
                input status, input run_last, input plane_done,
                input bytes_used, output ready);
endinterface

// File: src/pprle_ctrl.sv
// Sequencer for the plane decoder: byte decode, line store reads, pixel emission.
module pprle_ctrl import pprle_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.err_latched) begin
          // drop bytes until the end of the source
          cmd_o.restart = stat_i.last;
          state_d       = S_IDLE;
        end else begin
          cmd_o.count = 1'b1;
          if (stat_i.ctl_mode) begin
            priority if (stat_i.overflow) begin
              state_d = S_ERR_OVF;
            end else if (stat_i.last && !stat_i.ctl_fin_ok) begin
              state_d = S_ERR_EARLY;
            end else if (stat_i.ctl_raw_nz) begin
              cmd_o.set_pending = 1'b1;
              state_d           = S_IDLE;
            end else if (stat_i.ctl_run_nz) begin
              cmd_o.load_run = 1'b1;
              state_d        = S_RUN_RD;
            end else begin
              state_d = S_IDLE;
            end
          end else if (stat_i.last && !stat_i.raw_fin_ok) begin
            state_d = S_ERR_EARLY;
          end else begin
            state_d = S_RAW_RD;
          end
        end
      end
      S_ERR_OVF: begin
        if (stat_i.out_free) begin
          cmd_o.err_emit   = 1'b1;
          cmd_o.err_status = STATUS_OVERFLOW;
          cmd_o.restart    = stat_i.last;
          cmd_o.latch_err  = !stat_i.last;
          state_d          = S_IDLE;
        end
      end
      S_ERR_EARLY: begin
        if (stat_i.out_free) begin
          cmd_o.err_emit   = 1'b1;
          cmd_o.err_status = STATUS_EARLY_END;
          cmd_o.restart    = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_RAW_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_RAW_PIX;
      end
      S_RAW_PIX: begin
        if (stat_i.out_free) begin
          cmd_o.raw_pix = 1'b1;
          priority if (stat_i.pix_done) begin
            cmd_o.restart = 1'b1;
            state_d       = S_IDLE;
          end else if (stat_i.raw_left_one && !stat_i.run_left_zero) begin
            state_d = S_RUN_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RUN_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_RUN_PIX;
      end
      S_RUN_PIX: begin
        if (stat_i.out_free) begin
          cmd_o.run_pix = 1'b1;
          priority if (stat_i.pix_done) begin
            cmd_o.restart = 1'b1;
            state_d       = S_IDLE;
          end else if (stat_i.run_left_one) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_RUN_RD;
          end
        end
      end
    endcase
  end

endmodule

// File: src/pprle_dpath.sv
// Datapath: configuration, plane position, line store and output register.
module pprle_dpath import pprle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_idx_t            cfg_idx_i,
  input  logic [SIZE_W-1:0]   cfg_data_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  pprle_out_if.source         out_ch
);

  localparam logic [CNT_W-1:0]  CountMax = {CNT_W{1'b1}};
  localparam logic [SIZE_W-1:0] SizeMaxW = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] SizeMaxH = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] SizeOne  = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] SizeReset = SIZE_W'(64);

  logic [SIZE_W-1:0] width_q, height_q;
  logic              flip_q;
  logic [7:0]        byte_q;
  logic              last_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic              first_q;
  logic [RAW_W-1:0]  raw_left_q;
  logic [RUN_W-1:0]  run_left_q;
  logic [7:0]        carried_q;
  logic              err_q;
  logic [CNT_W-1:0]  bcnt_q;
  logic [7:0]        rd_data_q;
  logic [7:0]        line_mem [MAX_WIDTH];

  logic              out_valid_q;
  logic [7:0]        out_pix_q;
  logic [POS_W-1:0]  out_col_q, out_row_q;
  status_e           out_status_q;
  logic              out_last_q, out_done_q;
  logic [CNT_W-1:0]  out_bytes_q;

  logic              cfg_hit, restart;
  logic [SIZE_W-1:0] cfg_clamp_w, cfg_clamp_h;
  logic [RAW_W-1:0]  dec_raw;
  logic [RUN_W-1:0]  dec_run;
  logic [SIZE_W-1:0] col_ext, h_m1, ctl_sum;
  logic              lastrow, col_end, pix_done, pix_en, out_free;
  logic [7:0]        zigzag, delta, pix_val;
  logic [POS_W-1:0]  row_out;

  // Control byte decode: run codes 1 and 2 are extended runs with no raw bytes
  always_comb begin
    dec_raw = byte_q[7:4];
    dec_run = RUN_W'(byte_q[3:0]);
    if (byte_q[3:0] == 4'd1) begin
      dec_run = {2'b01, byte_q[7:4]};
      dec_raw = '0;
    end else if (byte_q[3:0] == 4'd2) begin
      dec_run = {2'b10, byte_q[7:4]};
      dec_raw = '0;
    end
  end

  assign col_ext  = SIZE_W'(col_q);
  assign h_m1     = height_q - SizeOne;
  assign lastrow  = (SIZE_W'(row_q) == h_m1);
  assign ctl_sum  = col_ext + SIZE_W'(dec_raw) + SIZE_W'(dec_run);
  assign col_end  = ((col_ext + SizeOne) == width_q);
  assign pix_done = col_end && lastrow;
  assign out_free = !out_valid_q || out_ch.ready;
  assign pix_en   = cmd_i.raw_pix || cmd_i.run_pix;

  assign stat_o.err_latched   = err_q;
  assign stat_o.last          = last_q;
  assign stat_o.ctl_mode      = (raw_left_q == '0);
  assign stat_o.overflow      = (ctl_sum > width_q);
  assign stat_o.ctl_fin_ok    = (dec_raw == '0) && (dec_run != '0) && lastrow &&
                                ((col_ext + SIZE_W'(dec_run)) == width_q);
  assign stat_o.raw_fin_ok    = (raw_left_q == RAW_W'(1)) && lastrow &&
                                ((col_ext + SizeOne + SIZE_W'(run_left_q)) == width_q);
  assign stat_o.ctl_raw_nz    = (dec_raw != '0);
  assign stat_o.ctl_run_nz    = (dec_run != '0);
  assign stat_o.raw_left_one  = (raw_left_q == RAW_W'(1));
  assign stat_o.run_left_zero = (run_left_q == '0);
  assign stat_o.run_left_one  = (run_left_q == RUN_W'(1));
  assign stat_o.pix_done      = pix_done;
  assign stat_o.out_free      = out_free;

  // Zigzag delta: even b gives b/2, odd b gives -(b/2 + 1)
  assign zigzag  = byte_q[0] ? {1'b1, ~byte_q[7:1]} : {1'b0, byte_q[7:1]};
  assign delta   = cmd_i.raw_pix ? (first_q ? byte_q : zigzag) : carried_q;
  assign pix_val = first_q ? delta : (rd_data_q + delta);
  assign row_out = flip_q ? POS_W'(h_m1 - SIZE_W'(row_q)) : POS_W'(row_q);

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == CFG_PLANE_WIDTH) ||
                                (cfg_idx_i == CFG_PLANE_HEIGHT) ||
                                (cfg_idx_i == CFG_VERTICAL_FLIP));
  assign restart = cmd_i.restart || cfg_hit;

  always_comb begin
    cfg_clamp_w = cfg_data_i;
    if (cfg_data_i == '0) cfg_clamp_w = SizeOne;
    else if (cfg_data_i > SizeMaxW) cfg_clamp_w = SizeMaxW;
    cfg_clamp_h = cfg_data_i;
    if (cfg_data_i == '0) cfg_clamp_h = SizeOne;
    else if (cfg_data_i > SizeMaxH) cfg_clamp_h = SizeMaxH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeReset;
      height_q <= SizeReset;
      flip_q   <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_PLANE_WIDTH) width_q <= cfg_clamp_w;
      if (cfg_idx_i == CFG_PLANE_HEIGHT) height_q <= cfg_clamp_h;
      if (cfg_idx_i == CFG_VERTICAL_FLIP) flip_q <= cfg_data_i[0];
    end
  end

  // Plane position and pending counts; restart wins over any update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      first_q    <= 1'b1;
      raw_left_q <= '0;
      run_left_q <= '0;
      carried_q  <= '0;
      err_q      <= 1'b0;
      bcnt_q     <= '0;
    end else if (restart) begin
      col_q      <= '0;
      row_q      <= '0;
      first_q    <= 1'b1;
      raw_left_q <= '0;
      run_left_q <= '0;
      carried_q  <= '0;
      err_q      <= 1'b0;
      bcnt_q     <= '0;
    end else begin
      if (cmd_i.count && (bcnt_q != CountMax)) bcnt_q <= bcnt_q + CNT_W'(1);
      if (cmd_i.latch_err) err_q <= 1'b1;
      if (cmd_i.set_pending) begin
        raw_left_q <= dec_raw;
        run_left_q <= dec_run;
      end
      if (cmd_i.load_run) run_left_q <= dec_run;
      if (cmd_i.raw_pix) raw_left_q <= raw_left_q - RAW_W'(1);
      if (cmd_i.run_pix) run_left_q <= run_left_q - RUN_W'(1);
      if (pix_en) begin
        if (col_end) begin
          col_q     <= '0;
          row_q     <= row_q + ROW_W'(1);
          first_q   <= 1'b0;
          carried_q <= '0;
        end else begin
          col_q     <= col_q + COL_W'(1);
          carried_q <= delta;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // Line store: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (pix_en) line_mem[col_q] <= pix_val;
    if (cmd_i.mem_rd) rd_data_q <= line_mem[col_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_en || cmd_i.err_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_en) begin
      out_pix_q    <= pix_val;
      out_status_q <= STATUS_PIXEL;
      out_done_q   <= pix_done;
      out_last_q   <= pix_done ||
                      (cmd_i.raw_pix ? !(stat_o.raw_left_one && !stat_o.run_left_zero)
                                     : stat_o.run_left_one);
    end else if (cmd_i.err_emit) begin
      out_pix_q    <= '0;
      out_status_q <= cmd_i.err_status;
      out_done_q   <= 1'b0;
      out_last_q   <= 1'b1;
    end
    if (pix_en || cmd_i.err_emit) begin
      out_col_q   <= POS_W'(col_q);
      out_row_q   <= row_out;
      out_bytes_q <= bcnt_q;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.pixel_value = out_pix_q;
  assign out_ch.column      = out_col_q;
  assign out_ch.row         = out_row_q;
  assign out_ch.status      = out_status_q;
  assign out_ch.run_last    = out_last_q;
  assign out_ch.plane_done  = out_done_q;
  assign out_ch.bytes_used  = out_bytes_q;

endmodule

// File: src/planar_plane_rle_decoder_unit.sv
// Sequence: a control byte is captured, then decoded; a raw byte is captured, decoded, read from
// the line store, then written to the line store and the output register; each further run pixel
// is a line store read, then a write. The sequencer takes one source byte at a time through a
// single line store port pair and accepts no new byte until it is done with the last. A full output
// register holds the sequencer until its transfer. Output register frees input.
// Reset: 64 x 64 plane, no flip, position and byte count cleared; line store not cleared.
module planar_plane_rle_decoder_unit import pprle_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  cfg_idx_t          cfg_idx_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  pprle_in_if.sink          in_ch,
  pprle_out_if.source       out_ch
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_ch.ready = in_ready;

  pprle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pprle_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .data_byte_i (in_ch.data_byte),
    .last_byte_i (in_ch.last_byte),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ch      (out_ch)
  );

endmodule
